// File: rtl/cbpe_pkg.sv
package cbpe_pkg;

   // curve resolution: sample k maps to t = k / STEPS
   localparam int unsigned STEPS = 100;

   localparam int unsigned IDX_W   = 7;
   localparam int unsigned COORD_W = 10;
   localparam int unsigned NUM_PTS = 4;
   localparam int unsigned NUM_AXES = 2;
   localparam int unsigned CSR_IDX_W = 4;

   localparam int unsigned K_W  = $clog2(STEPS + 1);
   localparam int unsigned KK_W = 2 * K_W;

   localparam longint unsigned DEN = longint'(STEPS) * STEPS * STEPS;
   localparam int unsigned W_W    = $clog2(DEN + 1);
   localparam int unsigned PROD_W = W_W + COORD_W;
   // numerator plus half the denominator stays below 2^COORD_W * DEN
   localparam int unsigned NUM_W  = PROD_W;

   // reciprocal of DEN; quotient estimate is low by at most one
   localparam int unsigned RCP_SH = NUM_W + 2;
   localparam longint unsigned RCP = (64'd1 << RCP_SH) / DEN;
   localparam int unsigned RCP_W  = $clog2(RCP + 1);

   // start register to strobe
   localparam int unsigned NUM_STAGES = 8;

   localparam int unsigned AXIS_X = 0;
   localparam int unsigned AXIS_Y = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CTRL_X0 = 4'd0,
      REG_CTRL_Y0 = 4'd1,
      REG_CTRL_X1 = 4'd2,
      REG_CTRL_Y1 = 4'd3,
      REG_CTRL_X2 = 4'd4,
      REG_CTRL_Y2 = 4'd5,
      REG_CTRL_X3 = 4'd6,
      REG_CTRL_Y3 = 4'd7
   } csr_index_type;

endpackage

// File: rtl/cubic_bezier_point_eval_core.sv
// cubic bezier point evaluator, fully pipelined
// rsp_valid pulses once the start transfer has passed through every pipeline stage
// throughput: one sample per clock; the multiplier stages set the depth
// busy never rises and results cannot be stalled
// reset clears the valid pipeline and all control points to zero
module cubic_bezier_point_eval_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cbpe_pkg::IDX_W-1:0]          req_sample_index,
   output logic                                rsp_valid,
   output logic [cbpe_pkg::COORD_W-1:0]        rsp_point_x,
   output logic [cbpe_pkg::COORD_W-1:0]        rsp_point_y,
   input  logic                                csr_write_enable,
   input  logic [cbpe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cbpe_pkg::COORD_W-1:0]        csr_wdata
);

   localparam int unsigned K_W     = cbpe_pkg::K_W;
   localparam int unsigned KK_W    = cbpe_pkg::KK_W;
   localparam int unsigned W_W     = cbpe_pkg::W_W;
   localparam int unsigned C_W     = cbpe_pkg::COORD_W;
   localparam int unsigned PROD_W  = cbpe_pkg::PROD_W;
   localparam int unsigned NUM_W   = cbpe_pkg::NUM_W;
   localparam int unsigned RCP_W   = cbpe_pkg::RCP_W;
   localparam int unsigned NPTS    = cbpe_pkg::NUM_PTS;
   localparam int unsigned NAX     = cbpe_pkg::NUM_AXES;
   localparam int unsigned NSTG    = cbpe_pkg::NUM_STAGES;

   logic accept;

   logic [C_W-1:0]      ctrl_ff [NPTS][NAX];
   logic [C_W-1:0]      ctrl_in [NPTS][NAX];

   logic [NSTG-1:0]     vld_ff, vld_in;

   logic [K_W-1:0]      k1_ff, k1_in, r1_ff, r1_in;

   logic [K_W-1:0]      k2_ff, r2_ff;
   logic [KK_W-1:0]     kk2_ff, kk2_in, rr2_ff, rr2_in, kr2_ff, kr2_in;

   logic [W_W-1:0]      w3_ff [NPTS];
   logic [W_W-1:0]      w3_in [NPTS];
   logic [KK_W+K_W-1:0] w0_full, w3_full;
   logic [KK_W+K_W+1:0] w1_full, w2_full;

   logic [PROD_W-1:0]   prod4_ff [NPTS][NAX];
   logic [PROD_W-1:0]   prod4_in [NPTS][NAX];

   logic [NUM_W-1:0]    num5_ff [NAX];
   logic [NUM_W-1:0]    num5_in [NAX];

   logic [NUM_W+RCP_W-1:0] rcp_full [NAX];
   logic [C_W-1:0]      q6_ff [NAX];
   logic [C_W-1:0]      q6_in [NAX];
   logic [NUM_W-1:0]    num6_ff [NAX];

   logic [NUM_W-1:0]    qd7_ff [NAX];
   logic [NUM_W-1:0]    qd7_in [NAX];
   logic [C_W-1:0]      q7_ff [NAX];
   logic [NUM_W-1:0]    num7_ff [NAX];

   logic [NUM_W-1:0]    rem8 [NAX];
   logic [C_W-1:0]      pt8_ff [NAX];
   logic [C_W-1:0]      pt8_in [NAX];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // control point registers
   always_comb begin
      ctrl_in = ctrl_ff;
      if (csr_write_enable) begin
         case (csr_index)
            cbpe_pkg::REG_CTRL_X0: ctrl_in[0][cbpe_pkg::AXIS_X] = csr_wdata;
            cbpe_pkg::REG_CTRL_Y0: ctrl_in[0][cbpe_pkg::AXIS_Y] = csr_wdata;
            cbpe_pkg::REG_CTRL_X1: ctrl_in[1][cbpe_pkg::AXIS_X] = csr_wdata;
            cbpe_pkg::REG_CTRL_Y1: ctrl_in[1][cbpe_pkg::AXIS_Y] = csr_wdata;
            cbpe_pkg::REG_CTRL_X2: ctrl_in[2][cbpe_pkg::AXIS_X] = csr_wdata;
            cbpe_pkg::REG_CTRL_Y2: ctrl_in[2][cbpe_pkg::AXIS_Y] = csr_wdata;
            cbpe_pkg::REG_CTRL_X3: ctrl_in[3][cbpe_pkg::AXIS_X] = csr_wdata;
            cbpe_pkg::REG_CTRL_Y3: ctrl_in[3][cbpe_pkg::AXIS_Y] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NPTS; p++) begin
            for (int a = 0; a < NAX; a++) begin
               ctrl_ff[p][a] <= '0;
            end
         end
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   // valid bits travel alongside the data
   assign vld_in = {vld_ff[NSTG-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: clamp k, form S - k
   always_comb begin
      if (32'(req_sample_index) > cbpe_pkg::STEPS) begin
         k1_in = K_W'(cbpe_pkg::STEPS);
      end else begin
         k1_in = K_W'(req_sample_index);
      end
      r1_in = K_W'(cbpe_pkg::STEPS) - k1_in;
   end

   // stage 2: squares and cross term
   always_comb begin
      kk2_in = k1_ff * k1_ff;
      rr2_in = r1_ff * r1_ff;
      kr2_in = k1_ff * r1_ff;
   end

   // stage 3: bernstein weights times S^3
   always_comb begin
      w0_full = rr2_ff * r2_ff;
      w1_full = kr2_ff * r2_ff * 2'd3;
      w2_full = kr2_ff * k2_ff * 2'd3;
      w3_full = kk2_ff * k2_ff;
      w3_in[0] = w0_full[W_W-1:0];
      w3_in[1] = w1_full[W_W-1:0];
      w3_in[2] = w2_full[W_W-1:0];
      w3_in[3] = w3_full[W_W-1:0];
   end

   // stage 4: weight times control coordinate
   always_comb begin
      for (int p = 0; p < NPTS; p++) begin
         for (int a = 0; a < NAX; a++) begin
            prod4_in[p][a] = w3_ff[p] * ctrl_ff[p][a];
         end
      end
   end

   // stage 5: numerator plus half the denominator for round-half-up
   always_comb begin
      for (int a = 0; a < NAX; a++) begin
         num5_in[a] = prod4_ff[0][a] + prod4_ff[1][a] + prod4_ff[2][a]
                    + prod4_ff[3][a] + NUM_W'(cbpe_pkg::DEN / 2);
      end
   end

   // stage 6: quotient estimate by reciprocal multiply
   always_comb begin
      for (int a = 0; a < NAX; a++) begin
         rcp_full[a] = num5_ff[a] * RCP_W'(cbpe_pkg::RCP);
         q6_in[a]    = rcp_full[a][cbpe_pkg::RCP_SH +: C_W];
      end
   end

   // stage 7: back-multiply the estimate
   always_comb begin
      for (int a = 0; a < NAX; a++) begin
         qd7_in[a] = q6_ff[a] * NUM_W'(cbpe_pkg::DEN);
      end
   end

   // stage 8: estimate may be one low, fix with the remainder
   always_comb begin
      for (int a = 0; a < NAX; a++) begin
         rem8[a] = num7_ff[a] - qd7_ff[a];
         if (rem8[a] >= NUM_W'(cbpe_pkg::DEN)) begin
            pt8_in[a] = q7_ff[a] + 1'b1;
         end else begin
            pt8_in[a] = q7_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      k1_ff   <= k1_in;
      r1_ff   <= r1_in;
      k2_ff   <= k1_ff;
      r2_ff   <= r1_ff;
      kk2_ff  <= kk2_in;
      rr2_ff  <= rr2_in;
      kr2_ff  <= kr2_in;
      w3_ff   <= w3_in;
      prod4_ff <= prod4_in;
      num5_ff <= num5_in;
      q6_ff   <= q6_in;
      num6_ff <= num5_ff;
      qd7_ff  <= qd7_in;
      q7_ff   <= q6_ff;
      num7_ff <= num6_ff;
      pt8_ff  <= pt8_in;
   end

   assign rsp_valid   = vld_ff[NSTG-1];
   assign rsp_point_x = pt8_ff[cbpe_pkg::AXIS_X];
   assign rsp_point_y = pt8_ff[cbpe_pkg::AXIS_Y];

endmodule

// File: rtl/cbpe_checker.sv
module cbpe_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid
);

   // every start transfer gives exactly one strobe after the pipeline depth
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(cbpe_pkg::NUM_STAGES) rsp_valid)
      else $error("missing result strobe");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##(cbpe_pkg::NUM_STAGES) !rsp_valid)
      else $error("result strobe without a start transfer");

   a_flush_on_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

endmodule

bind cubic_bezier_point_eval_core cbpe_checker u_cbpe_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
